[sv/assert_macros.svh]
// Assertion macros used by the slot directory engine RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Plain invariant checked at every edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  `ASSERT_CLK(lbl, (expr))

`endif

[sv/sde_pkg.sv]
// Package for the slot directory engine: sizes, command and status codes,
// and the shift control word handed to the slot cells. No dependencies.
`default_nettype none

package sde_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int MAX_SLOTS  = 512;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 12;
  localparam int AREA_W = 13;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 10;
  localparam int DIR_W  = 13;

  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERLAP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXCEEDS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] rec;
  } shift_ctrl_t;

endpackage

`default_nettype wire

[sv/sde_if.sv]
// Valid/ready channel interfaces for command and response words.
// Depends on sde_pkg for field widths.
`default_nettype none

interface sde_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [sde_pkg::CMD_W-1:0]  command;
  logic [sde_pkg::IDX_W-1:0]  slot_number;
  logic [sde_pkg::POS_W-1:0]  record_position;
  logic [sde_pkg::AREA_W-1:0] record_area_end;

  modport source (output valid, command, slot_number, record_position, record_area_end,
                  input ready);
  modport sink (input valid, command, slot_number, record_position, record_area_end,
                output ready);
endinterface

interface sde_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sde_pkg::STAT_W-1:0] status;
  logic [sde_pkg::POS_W-1:0]  read_position;
  logic [sde_pkg::CNT_W-1:0]  entry_count;
  logic [sde_pkg::DIR_W-1:0]  directory_start;

  modport source (output valid, status, read_position, entry_count, directory_start,
                  input ready);
  modport sink (input valid, status, read_position, entry_count, directory_start,
                output ready);
endinterface

`default_nettype wire

[sv/sde_cell.sv]
// One slot cell: holds one record offset and shifts with its neighbours.
// Depends on sde_pkg for the shift control word.
`default_nettype none

module sde_cell #(
  parameter int POS = 0
) (
  input  wire                          clk,
  input  wire  [sde_pkg::POS_W-1:0]    left,
  input  wire  [sde_pkg::POS_W-1:0]    right,
  input  wire  sde_pkg::shift_ctrl_t   ctrl,
  output logic [sde_pkg::POS_W-1:0]    value
);

  logic [31:0] idx_w;
  assign idx_w = 32'(ctrl.idx);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx_w == 32'(POS)) begin
        value <= ctrl.rec;
      end else if (idx_w < 32'(POS)) begin
        value <= left;
      end
    end else if (ctrl.rem && idx_w <= 32'(POS)) begin
      value <= right;
    end
  end

endmodule

`default_nettype wire

[sv/sde_chain.sv]
// Row of slot cells forming the directory, with the read select.
// Depends on sde_pkg and sde_cell.
`default_nettype none

module sde_chain #(
  parameter int MAX_SLOTS = sde_pkg::MAX_SLOTS
) (
  input  wire                          clk,
  input  wire  sde_pkg::shift_ctrl_t   ctrl,
  input  wire  [sde_pkg::IDX_W-1:0]    rd_idx,
  output logic [sde_pkg::POS_W-1:0]    rd_value
);

  logic [sde_pkg::POS_W-1:0] vals [MAX_SLOTS];

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic [sde_pkg::POS_W-1:0] lft;
    logic [sde_pkg::POS_W-1:0] rgt;
    if (i == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = vals[i-1];
    end
    if (i == MAX_SLOTS - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = vals[i+1];
    end
    sde_cell #(.POS(i)) u_cell (
      .clk   (clk),
      .left  (lft),
      .right (rgt),
      .ctrl  (ctrl),
      .value (vals[i])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (32'(rd_idx) == 32'(i)) begin
        rd_value = vals[i];
      end
    end
  end

endmodule

`default_nettype wire

[sv/slot_directory_engine.sv]
// Slot directory engine top level: command checks, count and start registers,
// response register, and the cell chain. Depends on sde_pkg, sde_if, sde_chain.
//
// Usage:
//   cmd carries command words (read, insert, remove a slot at an index, with
//   the record offset and current record area end); rsp carries one response
//   word per command: status, offset read, slot count and directory start.
//   Both channels move a word when valid and ready are high at a clock edge.
//   The response is registered: a command accepted at one edge shows its
//   response after that edge. One command per cycle is taken; in that same
//   cycle an insert or remove shifts every slot past the index in the chain.
//   cmd.ready is high whenever the response register is empty or being taken,
//   so a stalled receiver holds the response and stops new commands only
//   while it stalls.
//   Reset (rst, synchronous) empties the directory: count zero, start at the
//   page end, no response pending. Slot contents are not cleared; only slots
//   below the count are ever read.
`default_nettype none
`include "assert_macros.svh"

module slot_directory_engine #(
  parameter int PAGE_BYTES = sde_pkg::PAGE_BYTES,
  parameter int MAX_SLOTS  = sde_pkg::MAX_SLOTS
) (
  input wire        clk,
  input wire        rst,
  sde_cmd_if.sink   cmd,
  sde_rsp_if.source rsp
);

  localparam int TOT_W = $clog2(MAX_SLOTS + 1);
  localparam int BEG_W = $clog2(PAGE_BYTES + 1);
  localparam int AW0   = (BEG_W > TOT_W + 2) ? BEG_W : TOT_W + 2;
  localparam int AW1   = (AW0 > sde_pkg::AREA_W) ? AW0 : sde_pkg::AREA_W;
  localparam int AW    = AW1 + 2;

  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_next;
  logic [BEG_W-1:0] dir_begin;
  logic [BEG_W-1:0] dir_begin_next;

  logic                          out_valid;
  logic [sde_pkg::STAT_W-1:0]    out_status;
  logic [sde_pkg::POS_W-1:0]     out_pos;
  logic [sde_pkg::CNT_W-1:0]     out_count;
  logic [sde_pkg::DIR_W-1:0]     out_start;

  logic                          accept;
  logic [sde_pkg::STAT_W-1:0]    status_c;
  logic [sde_pkg::POS_W-1:0]     rd_value;
  logic [AW-1:0]                 idx_a;
  logic [AW-1:0]                 tot_a;
  logic [AW-1:0]                 beg_a;
  logic [AW-1:0]                 area_a;
  logic [AW-1:0]                 page_a;
  logic [AW-1:0]                 max_a;
  logic [AW-1:0]                 new_beg_a;
  sde_pkg::shift_ctrl_t          ctrl;

  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign idx_a     = AW'(cmd.slot_number);
  assign tot_a     = AW'(total);
  assign beg_a     = AW'(dir_begin);
  assign area_a    = AW'(cmd.record_area_end);
  assign page_a    = AW'(PAGE_BYTES);
  assign max_a     = AW'(MAX_SLOTS);
  assign new_beg_a = beg_a - AW'(2);

  always_comb begin
    status_c = sde_pkg::ST_BAD_INDEX;
    case (cmd.command)
      sde_pkg::CMD_READ: begin
        if (idx_a >= tot_a || idx_a >= max_a ||
            beg_a + (idx_a << 1) + AW'(2) > page_a) begin
          status_c = sde_pkg::ST_BAD_INDEX;
        end else begin
          status_c = sde_pkg::ST_OK;
        end
      end
      sde_pkg::CMD_INSERT: begin
        if (idx_a > tot_a) begin
          status_c = sde_pkg::ST_BAD_INDEX;
        end else if (beg_a < AW'(2) || new_beg_a < area_a) begin
          status_c = sde_pkg::ST_OVERLAP;
        end else if (new_beg_a + ((tot_a + AW'(1)) << 1) > page_a) begin
          status_c = sde_pkg::ST_EXCEEDS;
        end else if (tot_a >= max_a) begin
          status_c = sde_pkg::ST_FULL;
        end else begin
          status_c = sde_pkg::ST_OK;
        end
      end
      sde_pkg::CMD_REMOVE: begin
        if (idx_a >= tot_a) begin
          status_c = sde_pkg::ST_BAD_INDEX;
        end else begin
          status_c = sde_pkg::ST_OK;
        end
      end
      default: status_c = sde_pkg::ST_BAD_INDEX;
    endcase
  end

  always_comb begin
    ctrl.ins = accept && cmd.command == sde_pkg::CMD_INSERT && status_c == sde_pkg::ST_OK;
    ctrl.rem = accept && cmd.command == sde_pkg::CMD_REMOVE && status_c == sde_pkg::ST_OK;
    ctrl.idx = cmd.slot_number;
    ctrl.rec = cmd.record_position;
  end

  always_comb begin
    total_next     = total;
    dir_begin_next = dir_begin;
    if (ctrl.ins) begin
      total_next     = total + TOT_W'(1);
      dir_begin_next = dir_begin - BEG_W'(2);
    end else if (ctrl.rem) begin
      total_next     = total - TOT_W'(1);
      dir_begin_next = dir_begin + BEG_W'(2);
    end
  end

  sde_chain #(.MAX_SLOTS(MAX_SLOTS)) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .rd_idx   (cmd.slot_number),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      dir_begin <= BEG_W'(PAGE_BYTES);
      out_valid <= 1'b0;
    end else begin
      total     <= total_next;
      dir_begin <= dir_begin_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_c;
      out_pos    <= (cmd.command == sde_pkg::CMD_READ && status_c == sde_pkg::ST_OK) ?
                    rd_value : '0;
      out_count  <= sde_pkg::CNT_W'(total_next);
      out_start  <= sde_pkg::DIR_W'(dir_begin_next);
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.read_position   = out_pos;
  assign rsp.entry_count     = out_count;
  assign rsp.directory_start = out_start;

  `ASSERT_ALWAYS(a_begin_tracks_count, AW'(dir_begin) + (AW'(total) << 1) == page_a)
  `ASSERT_ALWAYS(a_count_in_range, AW'(total) <= max_a)
  `ASSERT_CLK(a_remove_drops_count, ctrl.rem |=> total == $past(total) - TOT_W'(1))
  `ASSERT_CLK(a_pos_zero_on_error,
    (rsp.valid && rsp.status != sde_pkg::ST_OK) |-> rsp.read_position == '0)

endmodule

`default_nettype wire

[tb/sv/slot_directory_engine_test.sv]
// Self-checking bench for slot_directory_engine: directed table, then random words.
// Uses sde_pkg and the sde_cmd_if/sde_rsp_if channels; replies are predicted
// from a shadow copy of the slot directory and checked in order.
`default_nettype none

module slot_directory_engine_test;
  import sde_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1725;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 8;
  localparam int HOLD_AT      = 200;
  localparam int DRAIN_AT     = 900;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  read_position;
    logic [CNT_W-1:0]  entry_count;
    logic [DIR_W-1:0]  directory_start;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  slot_number;
    logic [POS_W-1:0]  record_position;
    logic [AREA_W-1:0] record_area_end;
    logic              fixed;
    reply_t            want;
  } script_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_READ,   10'd0,    12'h000, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd0, 13'd4096}},
    '{CMD_REMOVE, 10'd0,    12'h000, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd0, 13'd4096}},
    '{CMD_INSERT, 10'd1,    12'h123, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd0, 13'd4096}},
    '{CMD_INSERT, 10'd0,    12'hFFF, 13'd4094, 1'b1, '{ST_OK,        12'h000, 10'd1, 13'd4094}},
    '{CMD_INSERT, 10'd0,    12'h000, 13'd4093, 1'b1, '{ST_OVERLAP,   12'h000, 10'd1, 13'd4094}},
    '{CMD_INSERT, 10'd1,    12'hABC, 13'd0,    1'b1, '{ST_OK,        12'h000, 10'd2, 13'd4092}},
    '{CMD_READ,   10'd0,    12'h000, 13'd0,    1'b1, '{ST_OK,        12'hFFF, 10'd2, 13'd4092}},
    '{CMD_READ,   10'd1,    12'h000, 13'd0,    1'b1, '{ST_OK,        12'hABC, 10'd2, 13'd4092}},
    '{CMD_READ,   10'd2,    12'h000, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd2, 13'd4092}},
    '{CMD_READ,   10'd1023, 12'h000, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd2, 13'd4092}},
    '{CMD_UNUSED, 10'd1,    12'hFFF, 13'd8191, 1'b1, '{ST_BAD_INDEX, 12'h000, 10'd2, 13'd4092}},
    '{CMD_INSERT, 10'd0,    12'h555, 13'd8191, 1'b1, '{ST_OVERLAP,   12'h000, 10'd2, 13'd4092}},
    '{CMD_INSERT, 10'd1023, 12'h555, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd2, 13'd4092}},
    '{CMD_INSERT, 10'd2,    12'h2AA, 13'd0,    1'b0, '0},
    '{CMD_INSERT, 10'd0,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_INSERT, 10'd1,    12'h800, 13'd4086, 1'b0, '0},
    '{CMD_READ,   10'd2,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_REMOVE, 10'd1,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_REMOVE, 10'd512,  12'h000, 13'd0,    1'b1, '{ST_BAD_INDEX, 12'h000, 10'd4, 13'd4088}},
    '{CMD_READ,   10'd3,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_REMOVE, 10'd3,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_REMOVE, 10'd0,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_READ,   10'd0,    12'h000, 13'd0,    1'b0, '0},
    '{CMD_READ,   10'd511,  12'h000, 13'd0,    1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  sde_cmd_if cmd_bus ();
  sde_rsp_if rsp_bus ();

  slot_directory_engine dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [POS_W-1:0] shadow_slots [MAX_SLOTS];
  int unsigned      shadow_count = 0;
  int unsigned      shadow_top   = PAGE_BYTES;
  reply_t           pending_replies [$];

  bit     calm         = 1'b0;
  bit     hold_request = 1'b0;
  int     stall_left   = 0;
  int     mismatches   = 0;
  int     words_sent   = 0;
  int     replies_seen = 0;
  int     idle_cycles  = 0;
  int     peak_count   = 0;
  int     status_seen [5] = '{default: 0};
  reply_t got;
  reply_t want;

  function automatic reply_t predict_reply(input logic [CMD_W-1:0]  c,
                                           input logic [IDX_W-1:0]  idx,
                                           input logic [POS_W-1:0]  rec,
                                           input logic [AREA_W-1:0] area);
    reply_t      r;
    int unsigned i;
    int unsigned at;
    at = idx;
    r.status        = ST_BAD_INDEX;
    r.read_position = '0;
    case (c)
      CMD_READ: begin
        if (at < shadow_count && at < MAX_SLOTS && shadow_top + 2 * at + 2 <= PAGE_BYTES) begin
          r.status        = ST_OK;
          r.read_position = shadow_slots[at];
        end
      end
      CMD_INSERT: begin
        if (at > shadow_count) begin
          r.status = ST_BAD_INDEX;
        end else if (shadow_top < 2 || shadow_top - 2 < area) begin
          r.status = ST_OVERLAP;
        end else if (shadow_top - 2 + 2 * (shadow_count + 1) > PAGE_BYTES) begin
          r.status = ST_EXCEEDS;
        end else if (shadow_count >= MAX_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > at; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[at] = rec;
          shadow_count++;
          shadow_top -= 2;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (at < shadow_count) begin
          for (i = at; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_count--;
          shadow_top += 2;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.entry_count     = CNT_W'(shadow_count);
    r.directory_start = DIR_W'(shadow_top);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic make_word(input phase_t ph,
                           output logic [CMD_W-1:0]  c,
                           output logic [IDX_W-1:0]  idx,
                           output logic [POS_W-1:0]  rec,
                           output logic [AREA_W-1:0] area);
    int ins_pct;
    int read_pct;
    int r;
    int lim;
    rec = POS_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 9) == 0) rec = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 99) < 4) begin
      c    = CMD_W'($urandom);
      idx  = IDX_W'($urandom);
      area = AREA_W'($urandom);
      return;
    end
    case (ph)
      PH_FILL:  begin ins_pct = 85; read_pct = 10; end
      PH_DRAIN: begin ins_pct = 5;  read_pct = 10; end
      default:  begin ins_pct = 35; read_pct = 35; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_pct) c = CMD_INSERT;
    else if (r < ins_pct + read_pct) c = CMD_READ;
    else c = CMD_REMOVE;
    lim = (c == CMD_INSERT) ? int'(shadow_count) : int'(shadow_count) - 1;
    if (lim < 0 || $urandom_range(0, 99) < 8) idx = IDX_W'($urandom_range(lim + 1, 1023));
    else idx = IDX_W'($urandom_range(0, lim));
    r = $urandom_range(0, 99);
    if (r < 10) area = AREA_W'($urandom_range(shadow_top - 1, 8191));
    else if (r < 20) area = AREA_W'(shadow_top - 2);
    else area = AREA_W'($urandom_range(0, shadow_top - 2));
  endtask

  task automatic send_word(input logic [CMD_W-1:0]  c,
                           input logic [IDX_W-1:0]  idx,
                           input logic [POS_W-1:0]  rec,
                           input logic [AREA_W-1:0] area,
                           input bit                fixed,
                           input reply_t            fixed_want,
                           input bit                drain_first);
    reply_t predicted;
    int     gap;
    gap = pick_gap();
    if (drain_first) begin
      cmd_bus.valid <= 1'b0;
      do @(negedge clk); while (pending_replies.size() != 0);
    end else if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid           <= 1'b1;
    cmd_bus.command         <= c;
    cmd_bus.slot_number     <= idx;
    cmd_bus.record_position <= rec;
    cmd_bus.record_area_end <= area;
    do @(posedge clk); while (!cmd_bus.ready);
    predicted = predict_reply(c, idx, rec, area);
    pending_replies.push_back(fixed ? fixed_want : predicted);
    words_sent++;
    if (int'(shadow_count) > peak_count) peak_count = shadow_count;
    @(negedge clk);
  endtask

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (calm) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:64]:  rsp_bus.ready <= 1'b1;
          [65:91]: begin
            stall_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
          end
          default: begin
            stall_left = $urandom_range(7, 39);
            rsp_bus.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[slot_directory_engine] ERROR");
      $finish;
    end
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.status          = rsp_bus.status;
      got.read_position   = rsp_bus.read_position;
      got.entry_count     = rsp_bus.entry_count;
      got.directory_start = rsp_bus.directory_start;
      replies_seen++;
      if (got.status < 5) status_seen[got.status]++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply with none pending: status %0d pos %0d count %0d start %0d",
                   got.status, got.read_position, got.entry_count, got.directory_start);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.read_position !== want.read_position ||
            got.entry_count !== want.entry_count ||
            got.directory_start !== want.directory_start) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply %0d st/pos/cnt/start: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     replies_seen, want.status, want.read_position, want.entry_count,
                     want.directory_start, got.status, got.read_position, got.entry_count,
                     got.directory_start);
        end
      end
    end
  end

  initial begin
    phase_t            phase;
    int                overfill;
    logic [CMD_W-1:0]  c;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  rec;
    logic [AREA_W-1:0] area;
    phase    = PH_FILL;
    overfill = 0;
    cmd_bus.valid           = 1'b0;
    cmd_bus.command         = CMD_READ;
    cmd_bus.slot_number     = '0;
    cmd_bus.record_position = '0;
    cmd_bus.record_area_end = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[n])
      send_word(SCRIPT[n].command, SCRIPT[n].slot_number, SCRIPT[n].record_position,
                SCRIPT[n].record_area_end, SCRIPT[n].fixed, SCRIPT[n].want, 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n == HOLD_AT) hold_request = 1'b1;
      case (phase)
        PH_FILL: begin
          if (shadow_count == MAX_SLOTS) overfill++;
          if (overfill > 25) phase = PH_DRAIN;
        end
        PH_DRAIN: if (shadow_count == 0) phase = PH_MIX;
        default: ;
      endcase
      make_word(phase, c, idx, rec, area);
      send_word(c, idx, rec, area, 1'b0, '0, n == DRAIN_AT);
    end
    cmd_bus.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d command words, checked %0d replies; directory peaked at %0d slots.",
             words_sent, replies_seen, peak_count);
    $display("Replies by status: ok %0d, bad index %0d, overlap %0d, exceeds %0d, full %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("[slot_directory_engine] OK");
    end else begin
      $display("%0d mismatching replies", mismatches);
      $display("[slot_directory_engine] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
